@@ rtl/core/cal_uvw_pkg.sv @@
// Shared types, fixed-point constants and rotation tables for the calorimeter UVW block.
`default_nettype none

package cal_uvw_pkg;

	// default hit coordinate width, 1/64 cm units
	localparam int POS_WIDTH_DFLT = 20;

	// Q2.16 coefficients
	localparam int COEF_W = 18;
	typedef logic signed [COEF_W-1:0] coef_t;

	// plane offsets in 1/4096 cm (1/64 cm with six fraction bits)
	localparam int OFS_W = 24;
	typedef logic signed [OFS_W-1:0] ofs_t;

	typedef logic [2:0] sector_t;

	localparam sector_t SECTOR_FIRST = 3'd0;
	localparam sector_t SECTOR_UP    = 3'd2;
	localparam sector_t SECTOR_BACK  = 3'd3;
	localparam sector_t SECTOR_LAST  = 3'd5;

	localparam coef_t SQRT3_Q16    = 18'sd113512;
	localparam coef_t SIN_TILT_Q16 = 18'sd27697;
	localparam coef_t INV_SINRHO   = 18'sd73626;
	localparam coef_t INV_TGRHO    = 18'sd33552;
	localparam coef_t INV_2COSRHO  = 18'sd71905;

	localparam ofs_t YLOW_Q6      = 24'sd749462;
	localparam ofs_t PLANE_SUM_Q6 = 24'sd2305581;

	// cos(tilt) * cos(phi)
	function automatic coef_t tc_cos(input sector_t k);
		coef_t c;
		case (k)
			3'd0: c = 18'sd59396;
			3'd1: c = 18'sd29698;
			3'd2: c = -18'sd29698;
			3'd3: c = -18'sd59396;
			3'd4: c = -18'sd29698;
			3'd5: c = 18'sd29698;
			default: c = 18'sd0;
		endcase
		return c;
	endfunction

	// cos(tilt) * sin(phi)
	function automatic coef_t tc_sin(input sector_t k);
		coef_t c;
		case (k)
			3'd0: c = 18'sd0;
			3'd1: c = 18'sd51438;
			3'd2: c = 18'sd51438;
			3'd3: c = 18'sd0;
			3'd4: c = -18'sd51438;
			3'd5: c = -18'sd51438;
			default: c = 18'sd0;
		endcase
		return c;
	endfunction

	// cos(phi)
	function automatic coef_t ph_cos(input sector_t k);
		coef_t c;
		case (k)
			3'd0: c = 18'sd65536;
			3'd1: c = 18'sd32768;
			3'd2: c = -18'sd32768;
			3'd3: c = -18'sd65536;
			3'd4: c = -18'sd32768;
			3'd5: c = 18'sd32768;
			default: c = 18'sd0;
		endcase
		return c;
	endfunction

	// sin(phi)
	function automatic coef_t ph_sin(input sector_t k);
		coef_t c;
		case (k)
			3'd0: c = 18'sd0;
			3'd1: c = 18'sd56756;
			3'd2: c = 18'sd56756;
			3'd3: c = 18'sd0;
			3'd4: c = -18'sd56756;
			3'd5: c = -18'sd56756;
			default: c = 18'sd0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/cal_uvw_sector.sv @@
// Two-stage azimuthal sector selection: sqrt(3) products, then half-plane tests.
`default_nettype none

module cal_uvw_sector import cal_uvw_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DFLT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [POS_WIDTH-1:0] x_pos,
	input  wire logic signed [POS_WIDTH-1:0] y_pos,
	input  wire logic signed [POS_WIDTH-1:0] z_pos,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [POS_WIDTH-1:0]      x_sec,
	output logic signed [POS_WIDTH-1:0]      y_sec,
	output logic signed [POS_WIDTH-1:0]      z_sec,
	output sector_t                          sector
);

	localparam int PW = POS_WIDTH;
	localparam int MW = PW + COEF_W;
	localparam int CW = PW + 19;

	logic                 v_s1, v_s2;
	logic                 rdy_s2;
	logic signed [PW-1:0] x_s1, y_s1, z_s1;
	logic signed [MW-1:0] mx_s1, my_s1;
	logic signed [PW-1:0] x_s2, y_s2, z_s2;
	sector_t              sector_s2;

	logic signed [CW-1:0] xsh, ysh;
	logic signed [CW-1:0] cr30, dt30, cr150, dt150;
	logic                 h30, h90, h150;
	sector_t              sector_n;

	// stage readiness: a stage loads when empty or when it drains
	assign rdy_s2   = !v_s2 || out_ready;
	assign in_ready = !v_s1 || rdy_s2;

	// stage 1: hold the position and form the sqrt(3) products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			x_s1  <= x_pos;
			y_s1  <= y_pos;
			z_s1  <= z_pos;
			mx_s1 <= x_pos * SQRT3_Q16;
			my_s1 <= y_pos * SQRT3_Q16;
		end
	end

	// cross and dot products against the 30 and 150 degree rays
	always_comb begin
		xsh   = CW'($signed({x_s1, 16'b0}));
		ysh   = CW'($signed({y_s1, 16'b0}));
		cr30  = CW'(my_s1) - xsh;
		dt30  = CW'(mx_s1) + ysh;
		cr150 = -CW'(my_s1) - xsh;
		dt150 = -CW'(mx_s1) + ysh;
		h30   = (cr30 > 0) || ((cr30 == 0) && (dt30 > 0));
		h150  = (cr150 > 0) || ((cr150 == 0) && (dt150 > 0));
		h90   = x_s1[PW-1] || ((x_s1 == 0) && (y_s1 > 0));
	end

	// combine the three half-plane flags into a sector
	always_comb begin
		if (h30) begin
			sector_n = 3'd1 + {2'b00, h90} + {2'b00, h150};
		end else if (h90) begin
			sector_n = 3'd4;
		end else if (h150) begin
			sector_n = 3'd5;
		end else begin
			sector_n = SECTOR_FIRST;
		end
	end

	// stage 2: register the sector with the position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			x_s2      <= x_s1;
			y_s2      <= y_s1;
			z_s2      <= z_s1;
			sector_s2 <= sector_n;
		end
	end

	assign out_valid = v_s2;
	assign x_sec     = x_s2;
	assign y_sec     = y_s2;
	assign z_sec     = z_s2;
	assign sector    = sector_s2;

	a_origin_sector0: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && (x_s2 == 0) && (y_s2 == 0)) |-> (sector_s2 == SECTOR_FIRST))
		else $error("hit on the z axis not in sector 0");

	a_neg_x_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && (y_s2 == 0) && (x_s2 < 0)) |-> (sector_s2 == SECTOR_BACK))
		else $error("hit on the negative x axis not in sector 3");

	a_pos_y_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && (x_s2 == 0) && (y_s2 > 0)) |-> (sector_s2 == SECTOR_UP))
		else $error("hit on the positive y axis not in sector 2");

endmodule

`default_nettype wire

@@ rtl/core/cal_uvw_rotate.sv @@
// Two-stage sector and tilt rotation: table products, then sum and round to 1/4096 cm.
`default_nettype none

module cal_uvw_rotate import cal_uvw_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DFLT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [POS_WIDTH-1:0] x_sec,
	input  wire logic signed [POS_WIDTH-1:0] y_sec,
	input  wire logic signed [POS_WIDTH-1:0] z_sec,
	input  wire sector_t                     sector,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [POS_WIDTH+9:0]      yi,
	output logic signed [POS_WIDTH+9:0]      xi,
	output sector_t                          sector_rot
);

	localparam int PW    = POS_WIDTH;
	localparam int MW    = PW + COEF_W;
	localparam int AW    = PW + 20;
	localparam int RW    = PW + 10;
	localparam int RND10 = 512;

	logic                 v_s3, v_s4;
	logic                 rdy_s4;
	logic signed [MW-1:0] tcx_s3, tsy_s3, tz_s3, pcy_s3, psx_s3;
	sector_t              sector_s3, sector_s4;
	logic signed [RW-1:0] yi_s4, xi_s4;
	logic signed [AW-1:0] ysum, xsum;

	assign rdy_s4   = !v_s4 || out_ready;
	assign in_ready = !v_s3 || rdy_s4;

	// stage 3: look up the sector coefficients and multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (in_ready) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			tcx_s3    <= x_sec * tc_cos(sector);
			tsy_s3    <= y_sec * tc_sin(sector);
			tz_s3     <= z_sec * SIN_TILT_Q16;
			pcy_s3    <= y_sec * ph_cos(sector);
			psx_s3    <= x_sec * ph_sin(sector);
			sector_s3 <= sector;
		end
	end

	// sum and add half an LSB before dropping ten fraction bits
	always_comb begin
		ysum = AW'(tcx_s3) + AW'(tsy_s3) - AW'(tz_s3) + AW'(RND10);
		xsum = AW'(pcy_s3) - AW'(psx_s3) + AW'(RND10);
	end

	// stage 4: register the rotated coordinates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			yi_s4     <= ysum[AW-1:10];
			xi_s4     <= xsum[AW-1:10];
			sector_s4 <= sector_s3;
		end
	end

	assign out_valid  = v_s4;
	assign yi         = yi_s4;
	assign xi         = xi_s4;
	assign sector_rot = sector_s4;

endmodule

`default_nettype wire

@@ rtl/core/cal_uvw_plane.sv @@
// Four-stage plane projection: offsets, slopes, rounding and saturation of U, V, W.
`default_nettype none

module cal_uvw_plane import cal_uvw_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DFLT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [POS_WIDTH+9:0] yi,
	input  wire logic signed [POS_WIDTH+9:0] xi,
	input  wire sector_t                     sector_rot,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [POS_WIDTH-1:0]      u_pos,
	output logic signed [POS_WIDTH-1:0]      v_pos,
	output logic signed [POS_WIDTH-1:0]      w_pos,
	output sector_t                          sector
);

	localparam int PW    = POS_WIDTH;
	localparam int RW    = PW + 10;
	localparam int DW    = RW + 1;
	localparam int MW    = DW + COEF_W;
	localparam int EW    = PW + 30;
	localparam int SW    = PW + 10;
	localparam int HW    = EW - 16;
	localparam int QW    = HW + COEF_W;
	localparam int RND16 = 1 << 15;
	localparam int RND22 = 1 << 21;

	logic                 v_s5, v_s6, v_s7, v_s8;
	logic                 rdy_s6, rdy_s7, rdy_s8;
	logic signed [MW-1:0] pu_s5, t_s5;
	logic signed [RW-1:0] xi_s5;
	sector_t              sector_s5, sector_s6, sector_s7, sector_s8;
	logic signed [PW-1:0] u_s6, v_s6q, u_s7, v_s7q, u_s8, v_s8q, w_s8;
	logic signed [HW-1:0] ws_s6;
	logic signed [QW-1:0] pw_s7;

	logic signed [DW-1:0] ud, td;
	logic signed [EW-1:0] xsh, u_sum, v_sum, ws_sum;
	logic signed [QW-1:0] w_sum;

	// clamp to the signed POS_WIDTH range
	function automatic logic signed [PW-1:0] sat_pos(input logic signed [SW-1:0] val);
		logic [SW-PW:0]       top;
		logic signed [PW-1:0] res;
		top = val[SW-1:PW-1];
		if ((&top) || !(|top)) begin
			res = val[PW-1:0];
		end else if (val[SW-1]) begin
			res = {1'b1, {(PW-1){1'b0}}};
		end else begin
			res = {1'b0, {(PW-1){1'b1}}};
		end
		return res;
	endfunction

	assign rdy_s8   = !v_s8 || out_ready;
	assign rdy_s7   = !v_s7 || rdy_s8;
	assign rdy_s6   = !v_s6 || rdy_s7;
	assign in_ready = !v_s5 || rdy_s6;

	// stage 5: apply plane offsets and multiply by the slopes
	always_comb begin
		ud = DW'(yi) + DW'(YLOW_Q6);
		td = DW'(PLANE_SUM_Q6) - DW'(yi);
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			pu_s5     <= ud * INV_SINRHO;
			t_s5      <= td * INV_TGRHO;
			xi_s5     <= xi;
			sector_s5 <= sector_rot;
		end
	end

	// U and V rounded to whole 1/64 cm units, W sum rounded to 1/4096 cm
	always_comb begin
		xsh    = EW'($signed({xi_s5, 16'b0}));
		u_sum  = EW'(pu_s5) + EW'(RND22);
		v_sum  = EW'(t_s5) - xsh + EW'(RND22);
		ws_sum = EW'(t_s5) + xsh + EW'(RND16);
	end

	// stage 6: saturate U and V, hold the W sum
	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			u_s6      <= sat_pos(SW'($signed(u_sum[EW-1:22])));
			v_s6q     <= sat_pos(SW'($signed(v_sum[EW-1:22])));
			ws_s6     <= ws_sum[EW-1:16];
			sector_s6 <= sector_s5;
		end
	end

	// stage 7: scale the W sum by 1/(2 cos rho)
	always_ff @(posedge clk) begin
		if (rdy_s7) begin
			pw_s7     <= ws_s6 * INV_2COSRHO;
			u_s7      <= u_s6;
			v_s7q     <= v_s6q;
			sector_s7 <= sector_s6;
		end
	end

	assign w_sum = pw_s7 + QW'(RND22);

	// stage 8: round and saturate W into the output register
	always_ff @(posedge clk) begin
		if (rdy_s8) begin
			w_s8      <= sat_pos(SW'($signed(w_sum[QW-1:22])));
			u_s8      <= u_s7;
			v_s8q     <= v_s7q;
			sector_s8 <= sector_s7;
		end
	end

	// advance valid bits through the four stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s5 <= in_valid;
			end
			if (rdy_s6) begin
				v_s6 <= v_s5;
			end
			if (rdy_s7) begin
				v_s7 <= v_s6;
			end
			if (rdy_s8) begin
				v_s8 <= v_s7;
			end
		end
	end

	assign out_valid = v_s8;
	assign u_pos     = u_s8;
	assign v_pos     = v_s8q;
	assign w_pos     = w_s8;
	assign sector    = sector_s8;

endmodule

`default_nettype wire

@@ rtl/core/calorimeter_xyz_to_uvw.sv @@
// Top level: hit position (x, y, z) to calorimeter U, V, W and sector.
//
//   channel  handshake            payload
//   in       in_valid / in_ready   x_pos, y_pos, z_pos (signed, 1/64 cm)
//   out      out_valid / out_ready u_pos, v_pos, w_pos (signed, 1/64 cm), sector
//
// One request per clock cycle while out_ready is high; the register chain has
// two stages that pick the sector, two that rotate, four that project onto the planes.
// Reset (arst_n, asynchronous) clears only the stage valid bits.
// Each stage loads when it is empty or draining, so a stall at out_ready holds
// full stages while earlier bubbles keep filling; nothing is dropped or repeated.
`default_nettype none

module calorimeter_xyz_to_uvw import cal_uvw_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DFLT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [POS_WIDTH-1:0] x_pos,
	input  wire logic signed [POS_WIDTH-1:0] y_pos,
	input  wire logic signed [POS_WIDTH-1:0] z_pos,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [POS_WIDTH-1:0]      u_pos,
	output logic signed [POS_WIDTH-1:0]      v_pos,
	output logic signed [POS_WIDTH-1:0]      w_pos,
	output sector_t                          sector
);

	logic                          sec_valid, sec_ready;
	logic signed [POS_WIDTH-1:0]   x_sec, y_sec, z_sec;
	sector_t                       sector_sec;
	logic                          rot_valid, rot_ready;
	logic signed [POS_WIDTH+9:0]   yi, xi;
	sector_t                       sector_rot;

	cal_uvw_sector #(
		.POS_WIDTH(POS_WIDTH)
	) u_sector (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.x_pos     (x_pos),
		.y_pos     (y_pos),
		.z_pos     (z_pos),
		.out_valid (sec_valid),
		.out_ready (sec_ready),
		.x_sec     (x_sec),
		.y_sec     (y_sec),
		.z_sec     (z_sec),
		.sector    (sector_sec)
	);

	cal_uvw_rotate #(
		.POS_WIDTH(POS_WIDTH)
	) u_rotate (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (sec_valid),
		.in_ready   (sec_ready),
		.x_sec      (x_sec),
		.y_sec      (y_sec),
		.z_sec      (z_sec),
		.sector     (sector_sec),
		.out_valid  (rot_valid),
		.out_ready  (rot_ready),
		.yi         (yi),
		.xi         (xi),
		.sector_rot (sector_rot)
	);

	cal_uvw_plane #(
		.POS_WIDTH(POS_WIDTH)
	) u_plane (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (rot_valid),
		.in_ready   (rot_ready),
		.yi         (yi),
		.xi         (xi),
		.sector_rot (sector_rot),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.u_pos      (u_pos),
		.v_pos      (v_pos),
		.w_pos      (w_pos),
		.sector     (sector)
	);

	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sector <= SECTOR_LAST))
		else $error("sector index out of range");

	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while the output drains");

endmodule

`default_nettype wire
